>>> rtl/lbmp_pkg.sv
// ----------------------------------------------------------------------------
// lbmp_pkg
// Shared types and constants for the Lucas binomial mod prime block.
// ----------------------------------------------------------------------------
package lbmp_pkg;

   localparam int PRIME_W   = 6;
   localparam int MAX_PRIME = 61;
   localparam int ADDR_W    = 2 * PRIME_W;

   localparam logic [PRIME_W-1:0] PRIME_RESET = 6'd2;

   // bit n set when n is prime, n < 64
   localparam logic [63:0] PRIME_MASK = 64'h28208A20_A08A28AC;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD,
      ST_CHECK,
      ST_MUL,
      ST_FIX,
      ST_READ,
      ST_MODMUL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic build_init;
      logic build_step;
      logic item_load;
      logic kill;
      logic mul;
      logic fix;
      logic rd;
      logic mm_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic build_last;
      logic prod_zero;
      logic bot_zero;
      logic bot_neg1;
      logic mm_last;
      logic out_free;
   } stat_type;

   function automatic logic prime_ok(input logic [PRIME_W-1:0] v);
      return PRIME_MASK[v] && (int'(v) <= MAX_PRIME);
   endfunction

endpackage

>>> rtl/lbmp_ctrl.sv
// ----------------------------------------------------------------------------
// lbmp_ctrl
// Sequencer: table build after a prime write, then the per-digit loop.
// ----------------------------------------------------------------------------
module lbmp_ctrl
   import lbmp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               csr_we,
   input  logic [PRIME_W-1:0] csr_wdata,
   input  stat_type           stat,
   output cmd_type            cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // a valid prime write wins; no transaction is taken in that cycle
            if (csr_we && prime_ok(csr_wdata)) begin
               cmd.build_init = 1'b1;
               state_in       = ST_BUILD;
            end else begin
               req_tready = 1'b1;
               if (req_tvalid) begin
                  cmd.item_load = 1'b1;
                  state_in      = ST_CHECK;
               end
            end
         end
         ST_BUILD: begin
            cmd.build_step = 1'b1;
            if (stat.build_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (stat.prod_zero || stat.bot_zero) begin
               state_in = ST_DONE;
            end else if (stat.bot_neg1) begin
               cmd.kill = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_MODMUL;
         end
         ST_MODMUL: begin
            cmd.mm_step = 1'b1;
            if (stat.mm_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/lbmp_dp.sv
// ----------------------------------------------------------------------------
// lbmp_dp
// Datapath: Pascal table memory and builder, reciprocal of the prime,
// floor divide by reciprocal multiply, modular product, output register.
// ----------------------------------------------------------------------------
module lbmp_dp
   import lbmp_pkg::*;
#(
   parameter int VALUE_BITS = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic [PRIME_W-1:0]    csr_wdata,
   input  logic [VALUE_BITS-1:0] top_value,
   input  logic [VALUE_BITS-1:0] bottom_value,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [PRIME_W-1:0]    residue
);

   localparam int VB    = VALUE_BITS;
   localparam int CNT_W = $clog2(VB + 2);

   // configuration and reciprocal floor(2^VB / p)
   logic [PRIME_W-1:0] prime_ff;
   logic [VB-1:0]      recip_ff;
   logic [PRIME_W-1:0] div_rem_ff;
   logic [CNT_W-1:0]   div_cnt_ff;
   logic               div_busy_ff;

   // table build
   logic [PRIME_W-1:0] x_ff;
   logic [PRIME_W-1:0] y_ff;
   logic [PRIME_W-1:0] prev_ff;
   logic [PRIME_W-1:0] row_ff [MAX_PRIME];
   logic [PRIME_W-1:0] tbl_mem [2**ADDR_W];
   logic [PRIME_W-1:0] new_entry;
   logic [PRIME_W:0]   pas_sum;

   // item state
   logic [VB-1:0]      top_ff;
   logic [VB-1:0]      bot_ff;
   logic [PRIME_W-1:0] prod_ff;
   logic [VB-1:0]      tmag_ff;
   logic [VB-1:0]      bmag_ff;
   logic               tneg_ff;
   logic               bneg_ff;
   logic [VB-1:0]      tq0_ff;
   logic [VB-1:0]      bq0_ff;
   logic [PRIME_W-1:0] tr_ff;
   logic [PRIME_W-1:0] br_ff;
   logic [PRIME_W-1:0] rd_ff;
   logic [PRIME_W-1:0] acc_ff;
   logic [2:0]         mm_cnt_ff;

   logic               rsp_tvalid_ff;
   logic [PRIME_W-1:0] residue_ff;

   logic [VB-1:0]      tmag;
   logic [VB-1:0]      bmag;
   logic [2*VB-1:0]    tprod;
   logic [2*VB-1:0]    bprod;
   logic [VB+PRIME_W-1:0] tfix;
   logic [VB+PRIME_W-1:0] bfix;
   logic [PRIME_W+1:0] mm_sum;
   logic [PRIME_W+1:0] mm_red1;
   logic [PRIME_W+1:0] mm_red2;
   logic [PRIME_W:0]   div_t;
   logic               build_last;

   // one correction step after q0 = floor(mag * recip / 2^VB), then the
   // negative case maps back through ~x = -x - 1
   function automatic logic [VB+PRIME_W-1:0] fix_digit(
      input logic [VB-1:0]      mag,
      input logic [VB-1:0]      q0,
      input logic               neg,
      input logic [PRIME_W-1:0] p
   );
      logic [VB-1:0]      qp;
      logic [VB-1:0]      r0;
      logic [PRIME_W:0]   r7;
      logic [VB-1:0]      q;
      logic [PRIME_W-1:0] r;
      qp = q0 * {{(VB-PRIME_W){1'b0}}, p};
      r0 = mag - qp;
      r7 = r0[PRIME_W:0];
      if (r7 >= {1'b0, p}) begin
         q = q0 + {{(VB-1){1'b0}}, 1'b1};
         r = PRIME_W'(r7 - {1'b0, p});
      end else begin
         q = q0;
         r = r7[PRIME_W-1:0];
      end
      if (neg) begin
         return {~q, PRIME_W'(p - r - PRIME_W'(1))};
      end
      return {q, r};
   endfunction

   assign tmag  = top_ff[VB-1] ? ~top_ff : top_ff;
   assign bmag  = bot_ff[VB-1] ? ~bot_ff : bot_ff;
   assign tprod = tmag * recip_ff;
   assign bprod = bmag * recip_ff;
   assign tfix  = fix_digit(tmag_ff, tq0_ff, tneg_ff, prime_ff);
   assign bfix  = fix_digit(bmag_ff, bq0_ff, bneg_ff, prime_ff);

   assign pas_sum   = {1'b0, prev_ff} + {1'b0, row_ff[0]};
   assign new_entry = (y_ff == '0) ? PRIME_W'(1) :
                      (pas_sum >= {1'b0, prime_ff}) ? PRIME_W'(pas_sum - {1'b0, prime_ff}) :
                      pas_sum[PRIME_W-1:0];
   assign build_last = (x_ff == prime_ff - PRIME_W'(1)) &&
                       (y_ff == PRIME_W'(MAX_PRIME - 1));

   // prod * d mod p, one bit of d per cycle from the top
   assign mm_sum  = {1'b0, acc_ff, 1'b0} +
                    (rd_ff[mm_cnt_ff] ? {2'b00, prod_ff} : '0);
   assign mm_red1 = (mm_sum >= {2'b00, prime_ff}) ? mm_sum - {2'b00, prime_ff} : mm_sum;
   assign mm_red2 = (mm_red1 >= {2'b00, prime_ff}) ? mm_red1 - {2'b00, prime_ff} : mm_red1;

   assign div_t = {div_rem_ff, (div_cnt_ff == CNT_W'(VB))};

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff    <= PRIME_RESET;
         div_busy_ff <= 1'b0;
      end else if (cmd.build_init) begin
         prime_ff    <= csr_wdata;
         div_busy_ff <= 1'b1;
      end else if (div_busy_ff && div_cnt_ff == '0) begin
         div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.build_init) begin
         div_rem_ff <= '0;
         div_cnt_ff <= CNT_W'(VB);
         recip_ff   <= '0;
      end else if (div_busy_ff) begin
         if (div_t >= {1'b0, prime_ff}) begin
            div_rem_ff <= PRIME_W'(div_t - {1'b0, prime_ff});
            recip_ff   <= {recip_ff[VB-2:0], 1'b1};
         end else begin
            div_rem_ff <= div_t[PRIME_W-1:0];
            recip_ff   <= {recip_ff[VB-2:0], 1'b0};
         end
         div_cnt_ff <= div_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.build_init) begin
         x_ff <= '0;
         y_ff <= '0;
         for (int i = 0; i < MAX_PRIME; i++) begin
            row_ff[i] <= '0;
         end
      end else if (cmd.build_step) begin
         prev_ff <= row_ff[0];
         for (int i = 0; i < MAX_PRIME - 1; i++) begin
            row_ff[i] <= row_ff[i+1];
         end
         row_ff[MAX_PRIME-1] <= new_entry;
         if (y_ff == PRIME_W'(MAX_PRIME - 1)) begin
            y_ff <= '0;
            x_ff <= x_ff + PRIME_W'(1);
         end else begin
            y_ff <= y_ff + PRIME_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.build_step) begin
         tbl_mem[{x_ff, y_ff}] <= new_entry;
      end
      if (cmd.rd) begin
         rd_ff <= tbl_mem[{tr_ff, br_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff <= PRIME_W'(1);
      end else if (cmd.item_load) begin
         prod_ff <= PRIME_W'(1);
      end else if (cmd.kill && top_ff != '1) begin
         prod_ff <= '0;
      end else if (cmd.mm_step && mm_cnt_ff == '0) begin
         prod_ff <= mm_red2[PRIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         top_ff <= top_value;
         bot_ff <= bottom_value;
      end else if (cmd.fix) begin
         top_ff <= tfix[VB+PRIME_W-1:PRIME_W];
         bot_ff <= bfix[VB+PRIME_W-1:PRIME_W];
      end
      if (cmd.mul) begin
         tmag_ff <= tmag;
         bmag_ff <= bmag;
         tneg_ff <= top_ff[VB-1];
         bneg_ff <= bot_ff[VB-1];
         tq0_ff  <= tprod[2*VB-1:VB];
         bq0_ff  <= bprod[2*VB-1:VB];
      end
      if (cmd.fix) begin
         tr_ff <= tfix[PRIME_W-1:0];
         br_ff <= bfix[PRIME_W-1:0];
      end
      if (cmd.rd) begin
         acc_ff    <= '0;
         mm_cnt_ff <= 3'(PRIME_W - 1);
      end else if (cmd.mm_step) begin
         acc_ff    <= mm_red2[PRIME_W-1:0];
         mm_cnt_ff <= mm_cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         residue_ff <= prod_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign residue    = residue_ff;

   assign stat.build_last = build_last;
   assign stat.prod_zero  = (prod_ff == '0);
   assign stat.bot_zero   = (bot_ff == '0);
   assign stat.bot_neg1   = (bot_ff == '1);
   assign stat.mm_last    = (mm_cnt_ff == '0);
   assign stat.out_free   = !rsp_tvalid_ff || rsp_tready;

`ifndef SYNTHESIS
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |-> (tr_ff < prime_ff) && (br_ff < prime_ff))
      else $error("digit not reduced below prime");

   a_modmul_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mm_step |-> (prod_ff < prime_ff) && (acc_ff < prime_ff))
      else $error("modular product operand out of range");

   a_recip_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.build_step && build_last) |-> !div_busy_ff)
      else $error("reciprocal not ready at end of table build");
`endif

endmodule

>>> rtl/lucas_binomial_mod_prime.sv
// ----------------------------------------------------------------------------
// lucas_binomial_mod_prime
// Binomial coefficient of two signed values modulo a small prime (Lucas).
// ----------------------------------------------------------------------------
// Input stream: req_tdata carries top_value and bottom_value; one residue
// comes back on the rsp stream for every input transaction.
// Configuration: a csr_we pulse with csr_wdata writes the prime. Values that
// are not a prime up to 61 are dropped. A valid write rebuilds the Pascal
// table, during which req_tready is low. A prime must be written after
// reset before the first transaction.
// Digits are base p and run until bottom reaches 0 or -1 or the product
// hits 0; up to about 32 digits for 32-bit values with p = 2. One digit is
// a check, reciprocal multiply, correction, table read and a bit-serial
// modular multiply.
// One transaction is processed at a time; req_tready is high only when idle.
// The result sits in an output register, so a new transaction is taken while
// the previous result waits; a stalled rsp_tready only holds the block at
// the end of the following transaction.
// Reset returns to idle with no result pending and the prime set to 2.
// ----------------------------------------------------------------------------
module lucas_binomial_mod_prime
   import lbmp_pkg::*;
#(
   parameter int VALUE_BITS = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [VALUE_BITS-1:0] top_value, [2*VALUE_BITS-1:VALUE_BITS] bottom_value
   input  logic [((2*VALUE_BITS+7)/8)*8-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [5:0] residue
   output logic [7:0]            rsp_tdata,
   input  logic                  csr_we,
   input  logic [PRIME_W-1:0]    csr_wdata
);

   cmd_type            cmd;
   stat_type           stat;
   logic [PRIME_W-1:0] residue;

   lbmp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .stat       (stat),
      .cmd        (cmd)
   );

   lbmp_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .csr_wdata    (csr_wdata),
      .top_value    (req_tdata[VALUE_BITS-1:0]),
      .bottom_value (req_tdata[2*VALUE_BITS-1:VALUE_BITS]),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .residue      (residue)
   );

   assign rsp_tdata = {{(8-PRIME_W){1'b0}}, residue};

endmodule

>>> bench/lucas_binomial_mod_prime_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lucas_binomial_mod_prime_test
// Drives signed top/bottom pairs through the block under several primes and
// checks each residue against a Lucas-theorem predictor kept in the bench.
// ----------------------------------------------------------------------------
module lucas_binomial_mod_prime_test
   import lbmp_pkg::*;
();

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // [31:0] top_value, [63:32] bottom_value
   logic [63:0]           req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [5:0] residue
   logic [7:0]            rsp_tdata;
   logic                  csr_we;
   logic [PRIME_W-1:0]    csr_wdata;

   int unsigned           modulus;
   logic [5:0]            pascal_mod [0:MAX_PRIME-1][0:MAX_PRIME-1];
   logic [5:0]            residue_queue [$];
   int                    mismatch_count;
   int                    unexpected_count;
   int                    hold_off_cycles;
   bit                    pattern_stall;

   lucas_binomial_mod_prime i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("simulation failed");
      $finish;
   end

   function automatic bit is_prime_value(input int unsigned v);
      if (v < 2 || v > MAX_PRIME) return 0;
      for (int d = 2; d * d <= v; d++)
         if (v % d == 0) return 0;
      return 1;
   endfunction

   // floor-division digit expansion, product of small binomials
   function automatic logic [5:0] lucas_residue(input logic signed [31:0] top_in,
                                                input logic signed [31:0] bot_in);
      longint t, b, p, tq, tr, bq, br;
      int unsigned prod;
      t = top_in;
      b = bot_in;
      p = modulus;
      prod = 1;
      while (prod != 0 && b != 0) begin
         tq = t / p; tr = t % p;
         bq = b / p; br = b % p;
         if (tr < 0) begin tr += p; tq--; end
         if (br < 0) begin br += p; bq--; end
         if (b == -1) begin
            if (t != -1) prod = 0;
            break;
         end
         prod = (prod * pascal_mod[tr][br]) % modulus;
         t = tq;
         b = bq;
      end
      return prod[5:0];
   endfunction

   task automatic write_prime(input int unsigned v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v[PRIME_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      if (is_prime_value(v)) begin
         modulus = v;
         for (int x = 0; x < MAX_PRIME; x++)
            for (int y = 0; y < MAX_PRIME; y++)
               pascal_mod[x][y] = '0;
         pascal_mod[0][0] = 6'd1;
         for (int x = 1; x < v; x++) begin
            pascal_mod[x][0] = 6'd1;
            for (int y = 1; y < v; y++)
               pascal_mod[x][y] = 6'((pascal_mod[x-1][y-1] + pascal_mod[x-1][y]) % v);
         end
      end
   endtask

   // leaves req_tvalid high; a gap or a drain drops it
   task automatic send_pair(input logic [31:0] top_in, input logic [31:0] bot_in);
      req_tvalid <= 1'b1;
      req_tdata  <= {bot_in, top_in};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      residue_queue.push_back(lucas_residue(top_in, bot_in));
      @(negedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (residue_queue.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic burst_gap;
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] random_value;
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 200);
         1: return -$urandom_range(1, 200);
         2: return $urandom;
         3: return 32'h7fff_ffff - $urandom_range(0, 3);
         4: return 32'h8000_0000 + $urandom_range(0, 3);
         default: return $urandom_range(0, 70000);
      endcase
   endfunction

   task automatic test_directed;
      logic [31:0] edge_vals [8] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff,
                                     32'h8000_0000, 32'd10, 32'hffff_fff6, 32'd61};
      write_prime(7);
      foreach (edge_vals[i]) send_pair(edge_vals[i], 32'h0);
      send_pair(32'hffff_ffff, 32'hffff_ffff);
      send_pair(32'd5, 32'hffff_ffff);
      send_pair(32'hffff_fffd, 32'd2);
      send_pair(32'd10, 32'd3);
      send_pair(32'd3, 32'd10);
      send_pair(32'd49, 32'd7);
      foreach (edge_vals[i]) send_pair(edge_vals[i], edge_vals[7-i]);
      drain();
   endtask

   task automatic test_random(input int unsigned prime_val, input int count);
      write_prime(prime_val);
      for (int i = 0; i < count; i++) begin
         send_pair(random_value(), random_value());
         burst_gap();
      end
      drain();
   endtask

   task automatic test_bad_writes;
      // non-primes and out-of-range must leave prime and table as they were
      write_prime(0);
      write_prime(1);
      write_prime(63);
      write_prime(62);
      write_prime(9);
      repeat (20) send_pair(random_value(), random_value());
      drain();
   endtask

   task automatic test_backpressure;
      write_prime(3);
      // long enough to cover the table build and two full transactions
      hold_off_cycles = 3000;
      for (int i = 0; i < 30; i++) send_pair(random_value(), random_value());
      drain();
   endtask

   initial begin
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0;
      rsp_tready = 1'b0; csr_we = 1'b0; csr_wdata = '0;
      mismatch_count = 0; unexpected_count = 0; hold_off_cycles = 0;
      modulus = 2;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(2, 150);
      test_random(61, 150);
      test_bad_writes();
      test_random(5, 150);
      test_backpressure();
      test_random(59, 150);
      test_random(13, 150);
      if (mismatch_count == 0 && unexpected_count == 0 && residue_queue.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // receiver: own stall pattern, plus a long counted hold-off when asked
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         if ($urandom_range(0, 15) == 0) pattern_stall <= ~pattern_stall;
         rsp_tready <= pattern_stall ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (residue_queue.size() == 0) begin
            unexpected_count++;
            $display("unexpected transaction: residue %0d", rsp_tdata[5:0]);
         end else begin
            if (rsp_tdata[5:0] !== residue_queue[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("residue mismatch: expected %0d actual %0d",
                           residue_queue[0], rsp_tdata[5:0]);
            end
            void'(residue_queue.pop_front());
         end
      end
   end

endmodule

>>> lucas_binomial_mod_prime.f
rtl/lbmp_pkg.sv
rtl/lbmp_ctrl.sv
rtl/lbmp_dp.sv
rtl/lucas_binomial_mod_prime.sv
bench/lucas_binomial_mod_prime_test.sv
